@@ rtl/dmab_pkg.sv @@
// shared constants and types of the double moving average band signal unit
package dmab_pkg;

  localparam int PRICE_FIELD_W = 32;
  localparam int SIDE_W        = 2;
  localparam int ACTION_W      = 2;
  localparam int SIZE_W        = 32;
  localparam int AVG_W         = 32;
  localparam int BAND_W        = 9;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 32;

  localparam int PRICE_WINDOW_DEF  = 16;
  localparam int SMOOTH_WINDOW_DEF = 8;
  localparam int PRICE_BITS_DEF    = 32;

  localparam int PERMILLE = 1000;

  localparam logic [BAND_W-1:0] BAND_MAX   = 9'd500;
  localparam logic [BAND_W-1:0] BAND_RESET = 9'd20;

  localparam logic [CFG_IDX_W-1:0] CFG_PER_TRADE_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_PERMILLE  = 1'd1;

  localparam logic [SIDE_W-1:0] SIDE_NONE  = 2'd0;
  localparam logic [SIDE_W-1:0] SIDE_LONG  = 2'd1;
  localparam logic [SIDE_W-1:0] SIDE_SHORT = 2'd2;

  localparam logic [ACTION_W-1:0] ACT_NONE  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_CLOSE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_LONG  = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_SHORT = 2'd3;

  typedef struct packed {
    logic [SIDE_W-1:0] side;
    logic              price_full;
    logic              smooth_full;
  } ctl_t;

endpackage

@@ rtl/dmab_ifs.sv @@
// channel interfaces of the double moving average band signal unit
interface dmab_in_if import dmab_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [PRICE_FIELD_W-1:0] close_price;
  logic [SIDE_W-1:0]        position_side;

  modport source (output valid, output close_price, output position_side, input ready);
  modport sink (input valid, input close_price, input position_side, output ready);
endinterface

interface dmab_out_if import dmab_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [SIZE_W-1:0]   trade_size;
  logic [AVG_W-1:0]    smoothed_average;
  logic                warmed_up;

  modport source (output valid, output action, output trade_size, output smoothed_average,
                  output warmed_up, input ready);
  modport sink (input valid, input action, input trade_size, input smoothed_average,
                input warmed_up, output ready);
endinterface

interface dmab_cfg_if import dmab_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/dmab_window.sv @@
// ring buffer with running sum and fill count, one pipeline stage
module dmab_window import dmab_pkg::*; #(
  parameter int DEPTH = PRICE_WINDOW_DEF,
  parameter int W     = PRICE_BITS_DEF,
  parameter int TW    = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        s_valid,
  output logic                        s_ready,
  input  logic                        s_push,
  input  logic [W-1:0]                s_val,
  input  logic [TW-1:0]               s_tag,
  output logic                        m_valid,
  input  logic                        m_ready,
  output logic [W+$clog2(DEPTH)-1:0]  m_sum,
  output logic                        m_full,
  output logic [TW-1:0]               m_tag
);

  localparam int SW = W + $clog2(DEPTH);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);

  logic [W-1:0]  ring_mem [DEPTH];
  logic [W-1:0]  old_r;
  logic [AW-1:0] slot_r;
  logic [AW-1:0] slot_nxt;
  logic [FW-1:0] fill_r;
  logic [FW-1:0] fill_nxt;
  logic [SW-1:0] sum_r;
  logic [SW-1:0] sum_nxt;
  logic [TW-1:0] tag_r;
  logic          v_r;
  logic          full_now;
  logic          take;
  logic          upd;

  assign s_ready  = !v_r || m_ready;
  assign take     = s_valid && s_ready;
  assign upd      = take && s_push;
  assign full_now = (fill_r == FW'(DEPTH));
  assign slot_nxt = (slot_r == AW'(DEPTH - 1)) ? '0 : slot_r + 1'b1;
  assign fill_nxt = full_now ? fill_r : fill_r + 1'b1;
  assign sum_nxt  = (sum_r - (full_now ? SW'(old_r) : '0)) + SW'(s_val);

  assign m_valid = v_r;
  assign m_sum   = sum_r;
  assign m_full  = full_now;
  assign m_tag   = tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r    <= 1'b0;
      slot_r <= '0;
      fill_r <= '0;
      sum_r  <= '0;
    end else begin
      if (s_ready) begin
        v_r <= s_valid;
      end
      if (upd) begin
        slot_r <= slot_nxt;
        fill_r <= fill_nxt;
        sum_r  <= sum_nxt;
      end
    end
  end

  // prefetch the entry that the next push replaces
  always_ff @(posedge clk) begin
    if (upd) begin
      ring_mem[slot_r] <= s_val;
      old_r <= (slot_nxt == slot_r) ? s_val : ring_mem[slot_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      tag_r <= s_tag;
    end
  end

endmodule

@@ rtl/dmab_cdiv.sv @@
// two stage divider by a constant window size
module dmab_cdiv import dmab_pkg::*; #(
  parameter int W  = 36,
  parameter int N  = PRICE_WINDOW_DEF,
  parameter int TW = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      s_valid,
  output logic                      s_ready,
  input  logic [W-1:0]              s_x,
  input  logic [TW-1:0]             s_tag,
  output logic                      m_valid,
  input  logic                      m_ready,
  output logic [W-$clog2(N)-1:0]    m_q,
  output logic [TW-1:0]             m_tag
);

  localparam int CL = $clog2(N);
  localparam int QW = W - CL;

  logic          va_r;
  logic          vb_r;
  logic          rdy_a;
  logic          rdy_b;
  logic          load_a;
  logic          load_b;
  logic [TW-1:0] ta_r;
  logic [TW-1:0] tb_r;
  logic [QW-1:0] q_r;

  assign rdy_b   = !vb_r || m_ready;
  assign rdy_a   = !va_r || rdy_b;
  assign s_ready = rdy_a;
  assign load_a  = s_valid && rdy_a;
  assign load_b  = va_r && rdy_b;
  assign m_valid = vb_r;
  assign m_q     = q_r;
  assign m_tag   = tb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (rdy_a) begin
        va_r <= s_valid;
      end
      if (rdy_b) begin
        vb_r <= va_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_a) begin
      ta_r <= s_tag;
    end
    if (load_b) begin
      tb_r <= ta_r;
    end
  end

  if (N == (1 << CL)) begin : g_shift
    logic [W-1:0] xa_r;

    always_ff @(posedge clk) begin
      if (load_a) begin
        xa_r <= s_x;
      end
      if (load_b) begin
        q_r <= QW'(xa_r >> CL);
      end
    end
  end else begin : g_recip
    // floor(x / N) = (x * ceil(2^S / N)) >> S, exact for x below 2^W
    localparam int S  = W + CL;
    localparam int MW = W + 2;
    localparam int XL = (W + 1) / 2;
    localparam int XH = W - XL;
    localparam int ML = (MW + 1) / 2;
    localparam int MH = MW - ML;
    localparam int PRW = W + MW;
    localparam logic [63:0] TWO_S = 64'd1 << S;
    localparam logic [63:0] MRC64 = (TWO_S + 64'(N) - 64'd1) / 64'(N);
    localparam logic [MW-1:0] MRC = MRC64[MW-1:0];
    localparam logic [ML-1:0] M_LO = MRC[ML-1:0];
    localparam logic [MH-1:0] M_HI = MRC[MW-1:ML];

    logic [XL+ML-1:0] pp_ll_r;
    logic [XL+MH-1:0] pp_lh_r;
    logic [XH+ML-1:0] pp_hl_r;
    logic [XH+MH-1:0] pp_hh_r;
    logic [PRW-1:0]   prod;

    assign prod = PRW'(pp_ll_r) + (PRW'(pp_lh_r) << ML) + (PRW'(pp_hl_r) << XL)
                + (PRW'(pp_hh_r) << (XL + ML));

    always_ff @(posedge clk) begin
      if (load_a) begin
        pp_ll_r <= (XL+ML)'(s_x[XL-1:0]) * (XL+ML)'(M_LO);
        pp_lh_r <= (XL+MH)'(s_x[XL-1:0]) * (XL+MH)'(M_HI);
        pp_hl_r <= (XH+ML)'(s_x[W-1:XL]) * (XH+ML)'(M_LO);
        pp_hh_r <= (XH+MH)'(s_x[W-1:XL]) * (XH+MH)'(M_HI);
      end
      if (load_b) begin
        q_r <= QW'(prod >> S);
      end
    end
  end

endmodule

@@ rtl/dmab_signal.sv @@
// band products, crossover decision and result register
module dmab_signal import dmab_pkg::*; #(
  parameter int PW = PRICE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                s_valid,
  output logic                s_ready,
  input  logic [PW-1:0]       s_price,
  input  logic [PW-1:0]       s_avg,
  input  ctl_t                s_ctl,
  input  logic [BAND_W-1:0]   band,
  input  logic [SIZE_W-1:0]   size_cfg,
  output logic                m_valid,
  input  logic                m_ready,
  output logic [ACTION_W-1:0] m_action,
  output logic [SIZE_W-1:0]   m_trade_size,
  output logic [AVG_W-1:0]    m_avg,
  output logic                m_warm
);

  localparam int PRW = PW + 11;

  logic                va_r;
  logic                vb_r;
  logic                rdy_a;
  logic                rdy_b;
  logic [BAND_W-1:0]   band_sat;
  logic [PW-1:0]       price_r;
  logic [PW-1:0]       avg_r;
  logic [SIDE_W-1:0]   side_r;
  logic                warm_r;
  logic [PRW-1:0]      p1000_r;
  logic [PRW-1:0]      upper_r;
  logic [PRW-1:0]      lower_r;
  logic [ACTION_W-1:0] act;
  logic [ACTION_W-1:0] action_r;
  logic [SIZE_W-1:0]   size_r;
  logic [AVG_W-1:0]    avg_out_r;
  logic                warm_out_r;

  assign rdy_b    = !vb_r || m_ready;
  assign rdy_a    = !va_r || rdy_b;
  assign s_ready  = rdy_a;
  assign band_sat = (band > BAND_MAX) ? BAND_MAX : band;

  assign m_valid      = vb_r;
  assign m_action     = action_r;
  assign m_trade_size = size_r;
  assign m_avg        = avg_out_r;
  assign m_warm       = warm_out_r;

  always_comb begin
    act = ACT_NONE;
    case (side_r)
      SIDE_LONG: begin
        if (price_r < avg_r) act = ACT_CLOSE;
      end
      SIDE_SHORT: begin
        if (price_r > avg_r) act = ACT_CLOSE;
      end
      SIDE_NONE: begin
        if (p1000_r > upper_r) act = ACT_LONG;
        else if (p1000_r < lower_r) act = ACT_SHORT;
      end
      default: act = ACT_NONE;
    endcase
    if (!warm_r) act = ACT_NONE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (rdy_a) begin
        va_r <= s_valid;
      end
      if (rdy_b) begin
        vb_r <= va_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && rdy_a) begin
      price_r <= s_price;
      avg_r   <= s_avg;
      side_r  <= s_ctl.side;
      warm_r  <= s_ctl.price_full && s_ctl.smooth_full;
      p1000_r <= PRW'(s_price) * PRW'(PERMILLE);
      upper_r <= PRW'(s_avg) * (PRW'(PERMILLE) + PRW'(band_sat));
      lower_r <= PRW'(s_avg) * (PRW'(PERMILLE) - PRW'(band_sat));
    end
    if (va_r && rdy_b) begin
      action_r   <= act;
      size_r     <= (act == ACT_LONG || act == ACT_SHORT) ? size_cfg : '0;
      avg_out_r  <= warm_r ? AVG_W'(avg_r) : '0;
      warm_out_r <= warm_r;
    end
  end

endmodule

@@ rtl/double_moving_average_band_signal_unit.sv @@
// top level of the double moving average band signal unit
//
// in_chan carries one bar per transaction: close price and open position side.
// out_chan returns exactly one result per bar: action, trade size, smoothed
// average and the warmed-up flag. cfg_chan writes per_trade_size (index 0)
// and band_permille (index 1); it is always ready. The user must write it
// only while idle; the unit does not enforce this. The unit accepts one bar
// per cycle while out_chan takes results. A bar passes the price window, two
// divider stages, smoothing window, two divider stages, band products and
// the result register. Each running sum closes its loop on its own register,
// which sets that rate. Each stage holds its item while the next one is full,
// so a stalled receiver fills the pipeline and in_chan.ready drops only once
// every stage holds a bar. Reset empties the pipeline and both windows, sets
// per_trade_size to 0 and band_permille to 20; ring contents are not cleared
// since an entry is only read back after it has been written.
module double_moving_average_band_signal_unit import dmab_pkg::*; #(
  parameter int PRICE_WINDOW  = PRICE_WINDOW_DEF,
  parameter int SMOOTH_WINDOW = SMOOTH_WINDOW_DEF,
  parameter int PRICE_BITS    = PRICE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  dmab_in_if.sink     in_chan,
  dmab_out_if.source  out_chan,
  dmab_cfg_if.sink    cfg_chan
);

  localparam int PW  = (PRICE_BITS < PRICE_FIELD_W) ? PRICE_BITS : PRICE_FIELD_W;
  localparam int PSW = PW + $clog2(PRICE_WINDOW);
  localparam int SSW = PW + $clog2(SMOOTH_WINDOW);
  localparam int TW  = PW + $bits(ctl_t);

  logic [SIZE_W-1:0] size_cfg_r;
  logic [BAND_W-1:0] band_cfg_r;

  logic [TW-1:0]  in_tag;
  logic           w1_valid;
  logic           w1_ready;
  logic [PSW-1:0] w1_sum;
  logic           w1_full;
  logic [TW-1:0]  w1_tag;
  logic [PW-1:0]  w1_price;
  ctl_t           w1_ctl;
  logic [TW-1:0]  d1_in_tag;
  logic           d1_valid;
  logic           d1_ready;
  logic [PW-1:0]  d1_q;
  logic [TW-1:0]  d1_tag;
  logic [PW-1:0]  d1_price;
  ctl_t           d1_ctl;
  logic           w2_valid;
  logic           w2_ready;
  logic [SSW-1:0] w2_sum;
  logic           w2_full;
  logic [TW-1:0]  w2_tag;
  logic [PW-1:0]  w2_price;
  ctl_t           w2_ctl;
  logic [TW-1:0]  d2_in_tag;
  logic           d2_valid;
  logic           d2_ready;
  logic [PW-1:0]  d2_q;
  logic [TW-1:0]  d2_tag;
  logic [PW-1:0]  d2_price;
  ctl_t           d2_ctl;
  logic           in_ready;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_cfg_r <= '0;
      band_cfg_r <= BAND_RESET;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        CFG_PER_TRADE_SIZE: size_cfg_r <= cfg_chan.data;
        CFG_BAND_PERMILLE:  band_cfg_r <= cfg_chan.data[BAND_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_chan.ready = in_ready;
  assign in_tag = {in_chan.close_price[PW-1:0],
                   ctl_t'{side: in_chan.position_side, price_full: 1'b0, smooth_full: 1'b0}};

  dmab_window #(.DEPTH(PRICE_WINDOW), .W(PW), .TW(TW)) u_price_win (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (in_chan.valid),
    .s_ready (in_ready),
    .s_push  (1'b1),
    .s_val   (in_chan.close_price[PW-1:0]),
    .s_tag   (in_tag),
    .m_valid (w1_valid),
    .m_ready (w1_ready),
    .m_sum   (w1_sum),
    .m_full  (w1_full),
    .m_tag   (w1_tag)
  );

  assign {w1_price, w1_ctl} = w1_tag;
  assign d1_in_tag = {w1_price,
                      ctl_t'{side: w1_ctl.side, price_full: w1_full, smooth_full: 1'b0}};

  dmab_cdiv #(.W(PSW), .N(PRICE_WINDOW), .TW(TW)) u_price_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (w1_valid),
    .s_ready (w1_ready),
    .s_x     (w1_sum),
    .s_tag   (d1_in_tag),
    .m_valid (d1_valid),
    .m_ready (d1_ready),
    .m_q     (d1_q),
    .m_tag   (d1_tag)
  );

  assign {d1_price, d1_ctl} = d1_tag;

  // the smoothing window only moves once the price window is full
  dmab_window #(.DEPTH(SMOOTH_WINDOW), .W(PW), .TW(TW)) u_smooth_win (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (d1_valid),
    .s_ready (d1_ready),
    .s_push  (d1_ctl.price_full),
    .s_val   (d1_q),
    .s_tag   (d1_tag),
    .m_valid (w2_valid),
    .m_ready (w2_ready),
    .m_sum   (w2_sum),
    .m_full  (w2_full),
    .m_tag   (w2_tag)
  );

  assign {w2_price, w2_ctl} = w2_tag;
  assign d2_in_tag = {w2_price,
                      ctl_t'{side: w2_ctl.side, price_full: w2_ctl.price_full,
                             smooth_full: w2_full}};

  dmab_cdiv #(.W(SSW), .N(SMOOTH_WINDOW), .TW(TW)) u_smooth_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (w2_valid),
    .s_ready (w2_ready),
    .s_x     (w2_sum),
    .s_tag   (d2_in_tag),
    .m_valid (d2_valid),
    .m_ready (d2_ready),
    .m_q     (d2_q),
    .m_tag   (d2_tag)
  );

  assign {d2_price, d2_ctl} = d2_tag;

  dmab_signal #(.PW(PW)) u_signal (
    .clk          (clk),
    .rst_n        (rst_n),
    .s_valid      (d2_valid),
    .s_ready      (d2_ready),
    .s_price      (d2_price),
    .s_avg        (d2_q),
    .s_ctl        (d2_ctl),
    .band         (band_cfg_r),
    .size_cfg     (size_cfg_r),
    .m_valid      (out_chan.valid),
    .m_ready      (out_chan.ready),
    .m_action     (out_chan.action),
    .m_trade_size (out_chan.trade_size),
    .m_avg        (out_chan.smoothed_average),
    .m_warm       (out_chan.warmed_up)
  );

endmodule
